// ----- sv/slot_free_list_allocator_defines.svh -----
// Shared assertion macros for the slot allocator.
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check that an expression holds at every clock edge out of reset.
`define SFLA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a cause implies an effect in the next cycle.
`define SFLA_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ----- sv/sfla_pkg.sv -----
`timescale 1ns / 1ps
package sfla_pkg;

    localparam int SLOT_COUNT  = 1024;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int STATUS_W    = 3;

    localparam int IN_TDATA_W  = ((SLOT_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = SLOT_W + STATUS_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd1;

    localparam logic MODE_RELEASE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_DISABLED     = 3'd1,
        ST_BEYOND       = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_FULL         = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_RESERVE  = 2'd0,
        KIND_RELEASE  = 2'd1,
        KIND_DISABLED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } q_rd_t;

endpackage

// ----- sv/slot_free_list_allocator.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tuser[0] mode, s_tdata[9:0] slot_index
// m_        out  m_tvalid/m_tready    m_tdata granted_slot, status, free_slots
// cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Each request passes through the back-end states S_READ and S_EXEC: S_READ reads the freed
// mark and the head link from the slot RAMs, S_EXEC decides, writes back and loads the result,
// and waits while m_ is stalled. A two-entry request queue keeps accepting, until it is full,
// while the back end or m_ is stalled. Reset is synchronous; no RAM clearing pass is needed,
// so requests are taken as soon as reset is released. Config writes are taken every cycle.
module slot_free_list_allocator
    import sfla_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // slot_index
    input  logic [0:0]             s_tuser,   // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // granted_slot, status, free_slots
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CNT_W-1:0] eff_limit;
    q_wr_t            q_wr;
    q_rd_t            q_rd;
    logic             q_full;
    logic             q_pop;
    req_t             wr_req, rd_req;

    sfla_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff_limit (eff_limit),
        .q_wr      (q_wr),
        .q_full    (q_full),
        .q_req     (wr_req)
    );

    sfla_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_req  (wr_req),
        .full    (q_full),
        .pop     (q_pop),
        .rd      (q_rd),
        .rd_req  (rd_req)
    );

    sfla_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_limit (eff_limit),
        .q_rd      (q_rd),
        .q_req     (rd_req),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- sv/sfla_ram.sv -----
`timescale 1ns / 1ps
module sfla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sfla_front.sv -----
`timescale 1ns / 1ps
module sfla_front
    import sfla_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [CNT_W-1:0]      eff_limit,
    output q_wr_t                 q_wr,
    input  logic                  q_full,
    output req_t                  q_req
);

    logic             pool_enabled_reg, pool_enabled_next;
    logic [CNT_W-1:0] slot_limit_reg, slot_limit_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        pool_enabled_next = pool_enabled_reg;
        slot_limit_next   = slot_limit_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_POOL_ENABLED) begin
                pool_enabled_next = cfg_data[0];
            end else if (cfg_index == CFG_SLOT_LIMIT) begin
                slot_limit_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_enabled_reg <= 1'b1;
            slot_limit_reg   <= CNT_W'(SLOT_COUNT);
        end else begin
            pool_enabled_reg <= pool_enabled_next;
            slot_limit_reg   <= slot_limit_next;
        end
    end

    // Fresh grants stop at the smaller of the limit and the pool size.
    assign eff_limit = (slot_limit_reg > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                            : slot_limit_reg;

    // Classify the request at the door; the user keeps the enable static while busy (not enforced here).
    always_comb begin
        q_req.slot = s_tdata[SLOT_W-1:0];
        if (!pool_enabled_reg) begin
            q_req.kind = KIND_DISABLED;
        end else if (s_tuser[0] == MODE_RELEASE) begin
            q_req.kind = KIND_RELEASE;
        end else begin
            q_req.kind = KIND_RESERVE;
        end
    end

    assign s_tready  = !q_full;
    assign q_wr.push = s_tvalid && !q_full;
    assign q_wr.full = q_full;

endmodule

// ----- sv/sfla_queue.sv -----
`timescale 1ns / 1ps
module sfla_queue
    import sfla_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t wr,
    input  req_t  wr_req,
    output logic  full,
    input  logic  pop,
    output q_rd_t rd,
    output req_t  rd_req
);

    localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);

    req_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_Q_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_Q_W'(QUEUE_DEPTH));
    assign rd.empty = (count_reg == '0);
    assign rd.pop   = pop;
    assign rd_req   = entry_reg[rptr_reg];
    assign do_push  = wr.push && !wr.full;
    assign do_pop   = pop && !rd.empty;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    always_comb begin
        wptr_next  = do_push ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next  = do_pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_Q_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_Q_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (do_push) begin
            entry_reg[wptr_reg] <= wr_req;
        end
    end

endmodule

// ----- sv/sfla_back.sv -----
`timescale 1ns / 1ps
`include "slot_free_list_allocator_defines.svh"
module sfla_back
    import sfla_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CNT_W-1:0]       eff_limit,
    input  q_rd_t                  q_rd,
    input  req_t                   q_req,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic {
        S_READ,
        S_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    req_t                   cur_reg, cur_next;
    logic [SLOT_W-1:0]      head_reg, head_next;
    logic [SLOT_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]       free_reg, free_next;
    logic [CNT_W-1:0]       hw_reg, hw_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   out_free, commit;
    status_t                status;
    logic [SLOT_W-1:0]      grant;

    logic                   mark_we, mark_wdata;
    logic [SLOT_W-1:0]      mark_waddr;
    logic                   mark_rdata;
    logic                   link_we;
    logic [SLOT_W-1:0]      link_rdata;

    sfla_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (q_rd.pop),
        .raddr (q_req.slot),
        .rdata (mark_rdata)
    );

    // Links of never-written entries come back only when the list has one slot or none.
    sfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (tail_reg),
        .wdata (cur_reg.slot),
        .re    (q_rd.pop),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    assign q_pop    = (state_reg == S_READ) && !q_rd.empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        hw_next    = hw_reg;
        status     = ST_OK;
        grant      = '0;
        mark_we    = 1'b0;
        mark_waddr = cur_reg.slot;
        mark_wdata = 1'b0;
        link_we    = 1'b0;

        unique case (cur_reg.kind)
            KIND_RESERVE: begin
                if (free_reg != '0) begin
                    grant      = head_reg;
                    mark_we    = commit;
                    mark_waddr = head_reg;
                    free_next  = CNT_W'(free_reg - 1'b1);
                    if (free_reg != CNT_W'(1)) begin
                        head_next = link_rdata;
                    end
                end else if (hw_reg < eff_limit) begin
                    // Fresh slot: its freed mark has never been set, write it clean.
                    grant      = hw_reg[SLOT_W-1:0];
                    mark_we    = commit;
                    mark_waddr = hw_reg[SLOT_W-1:0];
                    hw_next    = CNT_W'(hw_reg + 1'b1);
                end else begin
                    status = ST_FULL;
                end
            end
            KIND_RELEASE: begin
                if (CNT_W'(cur_reg.slot) >= hw_reg) begin
                    status = ST_BEYOND;
                end else if (mark_rdata) begin
                    status = ST_ALREADY_FREE;
                end else begin
                    mark_we    = commit;
                    mark_wdata = 1'b1;
                    tail_next  = cur_reg.slot;
                    free_next  = CNT_W'(free_reg + 1'b1);
                    if (free_reg != '0) begin
                        link_we = commit;
                    end else begin
                        head_next = cur_reg.slot;
                    end
                end
            end
            default: begin
                status = ST_DISABLED;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            S_READ: begin
                if (q_pop) begin
                    cur_next   = q_req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({free_next, status, grant});
                    state_next    = S_READ;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_READ;
            head_reg     <= '0;
            tail_reg     <= '0;
            free_reg     <= '0;
            hw_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                free_reg <= free_next;
                hw_reg   <= hw_next;
            end
        end
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SFLA_ASSERT_ALWAYS(a_free_within_used, free_reg <= hw_reg,
        "free list longer than slots used")
    `SFLA_ASSERT_ALWAYS(a_used_within_pool, hw_reg <= CNT_W'(SLOT_COUNT),
        "high water beyond pool")
    `SFLA_ASSERT_NEXT(a_exec_holds, (state_reg == S_EXEC) && !out_free,
        state_reg == S_EXEC, "request dropped while result stalled")
    `SFLA_ASSERT_NEXT(a_pop_enters_exec, q_pop, state_reg == S_EXEC,
        "popped request not executed")

endmodule
